// ===== src/cdoy_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdoy_pkg: shared types and calendar tables
// Transaction types for the day-of-year converter and the Gregorian
// month tables used by its pipeline stages.
// ----------------------------------------------------------------------------
package cdoy_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned OrdW   = 9;
  // Quotient of year / 100 fits in eight bits for a 14-bit year.
  localparam int unsigned QuotW  = 8;

  // Conversion direction codes.
  localparam logic FUNC_TO_ORDINAL   = 1'b0;
  localparam logic FUNC_FROM_ORDINAL = 1'b1;

  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;

  localparam logic [OrdW-1:0] DAYS_COMMON = 9'd365;
  localparam logic [OrdW-1:0] DAYS_LEAP   = 9'd366;

  typedef struct packed {
    logic              func;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [OrdW-1:0]   yearday;
  } in_t;

  typedef struct packed {
    logic              failed;
    logic [OrdW-1:0]   ordinal_day;
    logic [MonthW-1:0] result_month;
    logic [DayW-1:0]   result_day;
  } out_t;

  // Handoff from the leap-year stages to the conversion stages.
  typedef struct packed {
    logic valid;
    in_t  data;
    logic leap;
  } leap_stage_t;

  // Length of a month; zero for codes that are not a month.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = '0;
    endcase
    return n;
  endfunction

  // Number of days in the year before the first of month m.
  function automatic logic [OrdW-1:0] days_before(input logic [MonthW-1:0] m,
                                                   input logic leap);
    logic [OrdW-1:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && (m > MONTH_FEB) && (m <= MONTH_DEC)) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

// ===== src/cdoy_leap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdoy_leap: two-stage leap-year decision
// Divides the year by 100 with a reciprocal multiply in the first stage and
// forms the Gregorian leap decision from the remainder in the second.
// ----------------------------------------------------------------------------
module cdoy_leap (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  cdoy_pkg::in_t        in_data,
  output cdoy_pkg::leap_stage_t stage_out
);

  // 2^19 / 100 rounded up; exact for every 14-bit year.
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned RECIP_SH  = 19;
  localparam int unsigned ProdW     = cdoy_pkg::YearW + 13;

  logic                          v1_r;
  cdoy_pkg::in_t                 d1_r;
  logic [cdoy_pkg::QuotW-1:0]    q1_r;
  logic [ProdW-1:0]              prod;

  logic                          v2_r;
  cdoy_pkg::in_t                 d2_r;
  logic                          leap2_r;

  logic [cdoy_pkg::YearW:0]      q_times_100;
  logic                          rem_zero;
  logic                          leap_nxt;

  assign prod = ProdW'(in_data.year) * ProdW'(RECIP_100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_r    <= in_data;
    q1_r    <= prod[RECIP_SH +: cdoy_pkg::QuotW];
    d2_r    <= d1_r;
    leap2_r <= leap_nxt;
  end

  // q * 100 = q * 64 + q * 32 + q * 4
  always_comb begin
    q_times_100 = ({7'd0, q1_r} << 6) + ({7'd0, q1_r} << 5) + ({7'd0, q1_r} << 2);
    rem_zero    = (q_times_100 == {1'b0, d1_r.year});
    leap_nxt    = ((d1_r.year[1:0] == 2'b00) && !rem_zero) ||
                  (rem_zero && (q1_r[1:0] == 2'b00));
  end

  assign stage_out.valid = v2_r;
  assign stage_out.data  = d2_r;
  assign stage_out.leap  = leap2_r;

endmodule

// ===== src/cdoy_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdoy_conv: two-stage date conversion
// Checks the range and finds the month base offset in the first stage, then
// forms the ordinal day or the day of month in the output register.
// ----------------------------------------------------------------------------
module cdoy_conv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cdoy_pkg::leap_stage_t stage_in,
  output logic                  out_valid,
  output cdoy_pkg::out_t        out_data
);

  localparam int unsigned MonthW = cdoy_pkg::MonthW;
  localparam int unsigned OrdW   = cdoy_pkg::OrdW;
  localparam int unsigned DayW   = cdoy_pkg::DayW;

  logic                 v3_r;
  logic                 func3_r;
  logic                 fail3_r;
  logic [OrdW-1:0]      base3_r;
  logic [OrdW-1:0]      val3_r;
  logic [MonthW-1:0]    month3_r;

  logic                 fail_nxt;
  logic [OrdW-1:0]      base_nxt;
  logic [OrdW-1:0]      val_nxt;
  logic [MonthW-1:0]    month_nxt;
  logic [MonthW-1:0]    found;
  logic [OrdW-1:0]      limit;
  logic [DayW-1:0]      mlen;

  logic                 out_valid_r;
  cdoy_pkg::out_t       out_r;
  cdoy_pkg::out_t       out_nxt;
  logic [OrdW-1:0]      sum;
  logic [OrdW-1:0]      diff;

  always_comb begin
    mlen  = cdoy_pkg::month_len(stage_in.data.month, stage_in.leap);
    limit = stage_in.leap ? cdoy_pkg::DAYS_LEAP : cdoy_pkg::DAYS_COMMON;
    // First month whose last day is at or past the ordinal; December otherwise.
    found = cdoy_pkg::MONTH_DEC;
    for (int m = 11; m >= 1; m--) begin
      if (stage_in.data.yearday <=
          cdoy_pkg::days_before(MonthW'(m + 1), stage_in.leap)) begin
        found = MonthW'(m);
      end
    end
    if (stage_in.data.func == cdoy_pkg::FUNC_TO_ORDINAL) begin
      fail_nxt  = (stage_in.data.month < cdoy_pkg::MONTH_JAN) ||
                  (stage_in.data.month > cdoy_pkg::MONTH_DEC) ||
                  (stage_in.data.day == '0) || (stage_in.data.day > mlen);
      base_nxt  = cdoy_pkg::days_before(stage_in.data.month, stage_in.leap);
      val_nxt   = OrdW'(stage_in.data.day);
      month_nxt = '0;
    end else begin
      fail_nxt  = (stage_in.data.year == '0) || (stage_in.data.yearday == '0) ||
                  (stage_in.data.yearday > limit);
      base_nxt  = cdoy_pkg::days_before(found, stage_in.leap);
      val_nxt   = stage_in.data.yearday;
      month_nxt = found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v3_r        <= stage_in.valid;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    func3_r  <= stage_in.data.func;
    fail3_r  <= fail_nxt;
    base3_r  <= base_nxt;
    val3_r   <= val_nxt;
    month3_r <= month_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    sum  = base3_r + val3_r;
    diff = val3_r - base3_r;
    out_nxt = '0;
    if (fail3_r) begin
      out_nxt.failed = 1'b1;
    end else if (func3_r == cdoy_pkg::FUNC_TO_ORDINAL) begin
      out_nxt.ordinal_day = sum;
    end else begin
      out_nxt.result_month = month3_r;
      out_nxt.result_day   = diff[DayW-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/calendar_day_of_year_converter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_day_of_year_converter_core: Gregorian day-of-year converter
// Converts year/month/day to the ordinal day of the year, or year/ordinal
// back to month and day, with the 4/100/400 leap-year rule.
// ----------------------------------------------------------------------------
// A transaction is taken on every clock edge where start is high and busy is
// low. busy is high while reset is applied and for the first cycle after it,
// and low in every cycle from then on, so one transaction may be issued per
// cycle. Each result appears on out_data for exactly one cycle, marked by
// out_valid, once its transaction has passed through the four register
// stages: the divide-by-100 reciprocal multiply, the leap decision, the
// range check with month lookup, and the final add or subtract. Results
// come in issue order. The receiver cannot stall the block; it must capture
// every result in the cycle it is presented.
// ----------------------------------------------------------------------------
module calendar_day_of_year_converter_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cdoy_pkg::in_t  in_data,
  output logic           out_valid,
  output cdoy_pkg::out_t out_data
);

  // Busy only while reset is applied and the cycle right after it.
  logic                  busy_r;
  logic                  accept;
  cdoy_pkg::leap_stage_t leap_stage;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Stages one and two: year divided by 100 and the leap decision.
  cdoy_leap u_leap (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .stage_out (leap_stage)
  );

  // Stages three and four: validation, month lookup and the final result.
  cdoy_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage_in  (leap_stage),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== src/cdoy_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdoy_checker: port-level checks for the day-of-year converter
// Watches the top-level ports for latency and result consistency.
// ----------------------------------------------------------------------------
module cdoy_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input cdoy_pkg::out_t out_data
);

  // Every accepted transaction produces a result on out_valid.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted transaction produced no result");

  // No result appears without a matching accepted transaction before it.
  a_latency_rev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without a matching transaction");

  // A failed result carries zeros in every other field.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.failed) |->
      (out_data.ordinal_day == '0 && out_data.result_month == '0 &&
       out_data.result_day == '0))
    else $error("failed result has nonzero fields");

  // A good result holds either an ordinal day or a month/day, never both.
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.failed) |->
      ((out_data.ordinal_day != '0) != (out_data.result_month != '0)))
    else $error("good result fields inconsistent");

endmodule

bind calendar_day_of_year_converter_core cdoy_checker u_cdoy_checker (.*);
